// ----- src/lcrt_pkg.sv -----
// shared types and constants for the capture ring tap
package lcrt_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [2:0]  FRAME_RST   = 3'd4;

    // classified request as it sits in the queue
    typedef struct packed {
        logic       is_rd;
        logic       blk_end;
        logic [7:0] data;
    } t_item;

    // side information that travels with one word through the read pipe
    typedef struct packed {
        logic [3:0]  cnt;
        logic        last;
        logic [2:0]  s0;
        logic [9:0]  len;
        logic [31:0] bytes;
        logic [31:0] blocks;
        logic [31:0] reads;
    } t_rd_meta;

endpackage

// ----- src/lcrt_front.sv -----
// request intake: classify, clamp the read length, queue for the back end
module lcrt_front #(
    parameter int unsigned CAP_BYTES = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_kind,
    input  logic [7:0]                          i_byte,
    input  logic                                i_blk_end,
    input  logic [31:0]                         i_len,
    output logic                                o_q_valid,
    output lcrt_pkg::t_item                     o_q_item,
    output logic [$clog2(CAP_BYTES):0]          o_q_len,
    input  logic                                i_q_pop
);
    import lcrt_pkg::*;

    localparam int unsigned LEN_W = $clog2(CAP_BYTES) + 1;
    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_item              r_item [QUEUE_DEPTH];
    logic [LEN_W-1:0]   r_len  [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W:0]     r_cnt;

    logic               push;
    logic               pop;
    logic [LEN_W-1:0]   len_c;
    t_item              item_in;

    always_comb begin
        // anything above capacity is served as a full-ring request
        len_c = (i_len > 32'(CAP_BYTES)) ? LEN_W'(CAP_BYTES) : i_len[LEN_W-1:0];
        item_in.is_rd   = i_kind;
        item_in.blk_end = i_blk_end;
        item_in.data    = i_byte;
    end

    assign o_ready   = (r_cnt != (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_item[r_rp];
    assign o_q_len   = r_len[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_item[r_wp] <= item_in;
            r_len[r_wp]  <= len_c;
        end
    end

endmodule

// ----- src/lcrt_back.sv -----
// back end: ring banks, counters, length sizing and the word read pipe
module lcrt_back #(
    parameter int unsigned CAP_BYTES = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_data,
    input  logic                        i_q_valid,
    input  lcrt_pkg::t_item             i_q_item,
    input  logic [$clog2(CAP_BYTES):0]  i_q_len,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_data,
    output logic [3:0]                  o_count,
    output logic                        o_last,
    output logic [9:0]                  o_len,
    output logic [31:0]                 o_bytes,
    output logic [31:0]                 o_blocks,
    output logic [31:0]                 o_reads
);
    import lcrt_pkg::*;

    localparam int unsigned ADDR_W = $clog2(CAP_BYTES);
    localparam int unsigned LEN_W  = ADDR_W + 1;
    localparam int unsigned ROW_W  = ADDR_W - 3;
    localparam int unsigned ROWS   = CAP_BYTES / 8;
    localparam int unsigned IDX_W  = $clog2(LEN_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WANT,
        ST_CLAMP,
        ST_START,
        ST_ISSUE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_frame;
    logic [31:0]        r_bc;
    logic [31:0]        r_blk;
    logic [31:0]        r_rd;
    logic [2:0]         r_mod [2:7];
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_want;
    logic [LEN_W-1:0]   r_left;
    logic [2:0]         r_rem;
    logic [IDX_W-1:0]   r_idx;
    logic [ADDR_W-1:0]  r_pos;
    logic               r_bv;
    t_rd_meta           r_bm;
    logic               r_ov;
    logic [63:0]        r_o_data;
    t_rd_meta           r_o_meta;

    logic [2:0]         fr_eff;
    logic [2:0]         mod_sel;
    logic [3:0]         rem_t;
    logic [2:0]         rem_nx;
    logic               out_move;
    logic               b_move;
    logic               issue;
    logic [3:0]         cnt_i;
    logic               last_i;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   rd_addr [8];
    logic [7:0]         bank_q  [8];
    logic               wr_en;
    logic [2:0]         wbank;
    logic [ROW_W-1:0]   wrow;
    logic [63:0]        word;
    t_rd_meta           meta_i;

    always_comb begin
        fr_eff = (r_frame == 3'd0) ? 3'd1 : r_frame;
        unique case (fr_eff)
            3'd2:    mod_sel = r_mod[2];
            3'd3:    mod_sel = r_mod[3];
            3'd4:    mod_sel = r_mod[4];
            3'd5:    mod_sel = r_mod[5];
            3'd6:    mod_sel = r_mod[6];
            3'd7:    mod_sel = r_mod[7];
            default: mod_sel = 3'd0;
        endcase
        // one remainder bit per cycle, msb first
        rem_t  = {r_rem, r_len[r_idx]};
        rem_nx = (rem_t >= {1'b0, fr_eff}) ? 3'(rem_t - {1'b0, fr_eff}) : rem_t[2:0];
    end

    assign out_move = !r_ov || i_ready;
    assign b_move   = r_bv && out_move;
    assign issue    = (r_state == ST_ISSUE) && (!r_bv || b_move);
    assign cnt_i    = (r_left >= LEN_W'(8)) ? 4'd8 : r_left[3:0];
    assign last_i   = (r_left <= LEN_W'(8));
    assign row      = r_pos[ADDR_W-1:3];
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign wr_en    = o_q_pop && !i_q_item.is_rd;
    assign wbank    = r_bc[2:0];
    assign wrow     = r_bc[ADDR_W-1:3];

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            // banks below the start byte come from the next row
            rd_addr[b] = (3'(b) >= r_pos[2:0]) ? row : ROW_W'(row + 1'b1);
        end
        meta_i.cnt    = cnt_i;
        meta_i.last   = last_i;
        meta_i.s0     = r_pos[2:0];
        meta_i.len    = 10'(r_want);
        meta_i.bytes  = r_bc;
        meta_i.blocks = r_blk;
        meta_i.reads  = r_rd;
    end

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [7:0] r_mem [ROWS];
        logic [7:0] r_q;
        always_ff @(posedge i_clk) begin
            if (wr_en && (wbank == 3'(b))) begin
                r_mem[wrow] <= i_q_item.data;
            end
            if (issue) begin
                r_q <= r_mem[rd_addr[b]];
            end
        end
        assign bank_q[b] = r_q;
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            word[8*k +: 8] = (4'(k) < r_bm.cnt) ? bank_q[3'(r_bm.s0 + 3'(k))] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_frame <= FRAME_RST;
            r_bc    <= '0;
            r_blk   <= '0;
            r_rd    <= '0;
            for (int k = 2; k <= 7; k++) r_mod[k] <= '0;
            r_bv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) r_frame <= i_cfg_data;

            if (b_move) begin
                r_ov     <= 1'b1;
                r_o_data <= word;
                r_o_meta <= r_bm;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end

            if (issue) begin
                r_bv <= 1'b1;
                r_bm <= meta_i;
            end else if (b_move) begin
                r_bv <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.is_rd) begin
                            r_len   <= i_q_len;
                            r_rem   <= '0;
                            r_idx   <= IDX_W'(LEN_W - 1);
                            r_state <= ST_MOD;
                        end else begin
                            r_bc <= r_bc + 1'b1;
                            if (i_q_item.blk_end) r_blk <= r_blk + 1'b1;
                            // residues restart when the byte counter wraps
                            for (int k = 2; k <= 7; k++) begin
                                if ((&r_bc) || (r_mod[k] == 3'(k - 1))) begin
                                    r_mod[k] <= '0;
                                end else begin
                                    r_mod[k] <= r_mod[k] + 1'b1;
                                end
                            end
                        end
                    end
                end
                ST_MOD: begin
                    r_rem <= rem_nx;
                    if (r_idx == '0) begin
                        r_state <= ST_WANT;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_WANT: begin
                    r_want  <= r_len - LEN_W'(r_rem);
                    r_state <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    // not enough history: fall back to whole frames written so far
                    if ((r_want != '0) && (32'(r_want) > r_bc)) begin
                        r_want <= r_bc[LEN_W-1:0] - LEN_W'(mod_sel);
                    end
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_left  <= r_want;
                    r_pos   <= r_bc[ADDR_W-1:0] - r_want[ADDR_W-1:0];
                    if (r_want != '0) r_rd <= r_rd + 1'b1;
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: begin
                    if (issue) begin
                        r_left <= r_left - LEN_W'(cnt_i);
                        r_pos  <= r_pos + ADDR_W'(cnt_i);
                        if (last_i) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid  = r_ov;
    assign o_data   = r_o_data;
    assign o_count  = r_o_meta.cnt;
    assign o_last   = r_o_meta.last;
    assign o_len    = r_o_meta.len;
    assign o_bytes  = r_o_meta.bytes;
    assign o_blocks = r_o_meta.blocks;
    assign o_reads  = r_o_meta.reads;

`ifndef SYNTHESIS
    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !last_i) |-> (cnt_i == 4'd8))
        else $error("non-final word is not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (o_count == 4'd0)) |-> (o_last && (o_len == 10'd0)))
        else $error("zero-byte result is not a lone empty reply");

    a_read_sizing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_item.is_rd) |=> (r_state == ST_MOD))
        else $error("read request did not enter sizing");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && last_i) |=> (r_state == ST_IDLE))
        else $error("read did not finish after final word");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bv && !out_move) |=> (r_bv && $stable(r_bm)))
        else $error("read pipe lost a word under stall");
`endif

endmodule

// ----- src/lossy_capture_ring_tap_core.sv -----
// top level of the capture ring tap: stream ports, config port, front and back
//
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: data_byte, read_len; tlast; tuser
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: result fields; tlast
// cfg       in   i_cfg_we                          i_cfg_wdata: frame_bytes
//
// a write request is handled by the back end in ST_IDLE, so bytes stream at one per cycle while no read is in progress
// a read is sized by the bit-serial remainder step in ST_MOD, then ST_WANT, ST_CLAMP and ST_START,
// then issued as 8-byte words from the eight byte-wide ring banks, held while the output stalls
// reset clears counters and sets frame_bytes to 4; ring entries are read only after
// they were written, so there is no clearing pass
// a four-entry request queue keeps intake running while the output stalls, until it is full
module lossy_capture_ring_tap_core #(
    parameter int unsigned CAP_BYTES = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [39:0]   i_s_axis_tdata,   // data_byte [7:0], read_len [39:8]
    input  logic          i_s_axis_tlast,   // block_end
    input  logic          i_s_axis_tuser,   // req_type
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // read_data [63:0], byte_count [67:64], length_given [77:68],
    // byte_total [109:78], blocks_written [141:110], reads_done [173:142], zero pad
    output logic [175:0]  o_m_axis_tdata,
    output logic          o_m_axis_tlast,   // last
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_wdata       // frame_bytes
);
    import lcrt_pkg::*;

    localparam int unsigned LEN_W = $clog2(CAP_BYTES) + 1;

    logic               q_valid;
    t_item              q_item;
    logic [LEN_W-1:0]   q_len;
    logic               q_pop;
    logic [63:0]        rd_data;
    logic [3:0]         rd_count;
    logic [9:0]         rd_len;
    logic [31:0]        rd_bytes;
    logic [31:0]        rd_blocks;
    logic [31:0]        rd_reads;

    lcrt_front #(
        .CAP_BYTES (CAP_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_kind    (i_s_axis_tuser),
        .i_byte    (i_s_axis_tdata[7:0]),
        .i_blk_end (i_s_axis_tlast),
        .i_len     (i_s_axis_tdata[39:8]),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .o_q_len   (q_len),
        .i_q_pop   (q_pop)
    );

    lcrt_back #(
        .CAP_BYTES (CAP_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_wdata),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .i_q_len    (q_len),
        .o_q_pop    (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (rd_data),
        .o_count    (rd_count),
        .o_last     (o_m_axis_tlast),
        .o_len      (rd_len),
        .o_bytes    (rd_bytes),
        .o_blocks   (rd_blocks),
        .o_reads    (rd_reads)
    );

    assign o_m_axis_tdata = {2'b00, rd_reads, rd_blocks, rd_bytes, rd_len, rd_count, rd_data};

endmodule
